// ----- hw/rtl/bas_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Balanced argument scanner package
// Shared types, character codes and a helper function for the scanner.
// ----------------------------------------------------------------------------
package bas_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_LANGLE = 8'h3C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_RANGLE = 8'h3E;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        logic double_quoted;
        logic single_quoted;
        logic escaped;
        logic first_of_substring;
        logic pending_space_check;
        logic finished;
    } t_scan_flags;

    localparam t_scan_flags FLAGS_RESET = '{
        double_quoted:       1'b0,
        single_quoted:       1'b0,
        escaped:             1'b0,
        first_of_substring:  1'b1,
        pending_space_check: 1'b0,
        finished:            1'b0
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bas_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Balanced argument scanner channels
// Valid/ready channels for input characters and per-byte results.
// ----------------------------------------------------------------------------
interface bas_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       start_req;

    modport source (output valid, output ch, output start_req, input ready);
    modport sink   (input valid, input ch, input start_req, output ready);
endinterface

interface bas_out_if;
    logic        valid;
    logic        ready;
    logic        ended;
    logic [15:0] end_offset;

    modport source (output valid, output ended, output end_offset, input ready);
    modport sink   (input valid, input ended, input end_offset, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/balanced_argument_scanner.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Balanced argument scanner
// Finds the end of the first bracket- and quote-balanced argument of a string.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                       Transaction
//  i_in     in   ch[7:0], start_req            one character byte
//  o_out    out  ended, end_offset[15:0]       one result per byte
//
//  Each byte passes through an input register, then the step logic feeding
//  the result register and the scan state together. Unless o_out stalls,
//  one byte is accepted every cycle; the scan state is updated in the same
//  cycle the result register loads, so consecutive bytes see each other.
//  A stall on o_out holds the result; the input register still takes one
//  byte and i_in.ready drops only when both registers are full.
//  Reset (synchronous, active low) empties both registers and clears state.
// ----------------------------------------------------------------------------
module balanced_argument_scanner #(
    parameter int unsigned      MAX_DEPTH = 255,
    parameter longint unsigned  MAX_LEN   = 65535
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bas_in_if.sink      i_in,
    bas_out_if.source   o_out
);
    import bas_pkg::*;

    localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam logic [15:0] POS_LIMIT = (MAX_LEN < 65535) ? 16'(MAX_LEN) : 16'hFFFF;

    logic               r_in_valid;
    logic [7:0]         r_ch;
    logic               r_start_req;
    logic [DEPTH_W-1:0] r_depth;
    t_scan_flags        r_flags;
    logic [15:0]        r_pos;
    logic               r_out_valid;
    logic               r_ended;
    logic [15:0]        r_end_offset;

    logic [DEPTH_W-1:0] n_depth;
    t_scan_flags        n_flags;
    logic [15:0]        n_pos;
    logic               n_ended;
    logic [15:0]        n_end_offset;
    logic               advance;
    logic               in_ready;

    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || advance;

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.ended      = r_ended;
    assign o_out.end_offset = r_end_offset;

    bas_step #(
        .MAX_DEPTH (MAX_DEPTH),
        .DEPTH_W   (DEPTH_W),
        .POS_LIMIT (POS_LIMIT)
    ) u_step (
        .i_ch         (r_ch),
        .i_start_req  (r_start_req),
        .i_depth      (r_depth),
        .i_flags      (r_flags),
        .i_pos        (r_pos),
        .o_depth      (n_depth),
        .o_flags      (n_flags),
        .o_pos        (n_pos),
        .o_ended      (n_ended),
        .o_end_offset (n_end_offset)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_depth     <= '0;
            r_flags     <= FLAGS_RESET;
            r_pos       <= '0;
        end else begin
            if (in_ready) r_in_valid <= i_in.valid;
            if (advance) begin
                r_out_valid <= 1'b1;
                r_depth     <= n_depth;
                r_flags     <= n_flags;
                r_pos       <= n_pos;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_ch        <= i_in.ch;
            r_start_req <= i_in.start_req;
        end
        if (advance) begin
            r_ended      <= n_ended;
            r_end_offset <= n_end_offset;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/bas_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Balanced argument scanner step
// Next-state and result logic for one character byte.
// ----------------------------------------------------------------------------
module bas_step #(
    parameter int unsigned MAX_DEPTH = 255,
    parameter int unsigned DEPTH_W   = 8,
    parameter logic [15:0] POS_LIMIT = 16'hFFFF
) (
    input  wire logic [7:0]          i_ch,
    input  wire logic                i_start_req,
    input  wire logic [DEPTH_W-1:0]  i_depth,
    input  wire bas_pkg::t_scan_flags i_flags,
    input  wire logic [15:0]         i_pos,
    output logic [DEPTH_W-1:0]       o_depth,
    output bas_pkg::t_scan_flags     o_flags,
    output logic [15:0]              o_pos,
    output logic                     o_ended,
    output logic [15:0]              o_end_offset
);
    import bas_pkg::*;

    localparam logic [DEPTH_W-1:0]   DEPTH_CAP  = DEPTH_W'(MAX_DEPTH);
    localparam logic signed [DEPTH_W:0] DEPTH_STEP = (DEPTH_W+1)'(1);

    logic [DEPTH_W-1:0]    e_depth;
    t_scan_flags           e_flags;
    logic [15:0]           e_pos;
    logic [15:0]           pos_inc;
    logic                  quoted;
    logic                  raise;
    logic                  lower;
    logic signed [DEPTH_W:0] d_next;
    logic                  d_nonpos;

    // A start request clears all state before the byte is handled.
    assign e_depth = i_start_req ? '0 : i_depth;
    assign e_flags = i_start_req ? FLAGS_RESET : i_flags;
    assign e_pos   = i_start_req ? '0 : i_pos;
    assign pos_inc = (e_pos < POS_LIMIT) ? e_pos + 16'd1 : POS_LIMIT;
    assign quoted  = e_flags.double_quoted | e_flags.single_quoted;

    always_comb begin
        o_flags = e_flags;
        raise   = 1'b0;
        lower   = 1'b0;
        case (i_ch) inside
            CH_LBRACE, CH_LBRACK, CH_LPAREN, CH_LANGLE: begin
                if (!quoted) raise = 1'b1;
                else o_flags.escaped = 1'b0;
            end
            CH_RBRACE, CH_RBRACK, CH_RPAREN, CH_RANGLE: begin
                if (!quoted) lower = 1'b1;
                else o_flags.escaped = 1'b0;
            end
            CH_SQUOTE: begin
                if (e_flags.double_quoted || e_flags.escaped) begin
                    o_flags.escaped = 1'b0;
                end else begin
                    o_flags.single_quoted = !e_flags.single_quoted;
                    raise = !e_flags.single_quoted;
                    lower = e_flags.single_quoted;
                end
            end
            CH_DQUOTE: begin
                if (e_flags.single_quoted || e_flags.escaped) begin
                    o_flags.escaped = 1'b0;
                end else begin
                    o_flags.double_quoted = !e_flags.double_quoted;
                    raise = !e_flags.double_quoted;
                    lower = e_flags.double_quoted;
                end
            end
            CH_BSLASH: begin
                if (quoted) o_flags.escaped = !e_flags.escaped;
            end
            default: begin
                if (quoted) o_flags.escaped = 1'b0;
            end
        endcase

        // Raises beyond the cap are dropped, so depth never reaches the sign bit.
        if (raise && (e_depth < DEPTH_CAP)) d_next = $signed({1'b0, e_depth}) + DEPTH_STEP;
        else if (lower) d_next = $signed({1'b0, e_depth}) - DEPTH_STEP;
        else d_next = $signed({1'b0, e_depth});
        d_nonpos = d_next[DEPTH_W] || (d_next == '0);

        o_depth      = e_depth;
        o_pos        = e_pos;
        o_ended      = 1'b0;
        o_end_offset = '0;

        if (!e_flags.finished) begin
            if ((i_ch == CH_NUL) || (e_flags.pending_space_check && is_ws(i_ch))) begin
                o_flags      = e_flags;
                o_ended      = 1'b1;
                o_end_offset = e_pos;
            end else begin
                o_flags.pending_space_check = 1'b0;
                if (d_nonpos) begin
                    if (e_flags.first_of_substring) begin
                        // A one-byte substring: the argument may end at a following space.
                        o_flags.pending_space_check = 1'b1;
                        o_flags.double_quoted       = 1'b0;
                        o_flags.single_quoted       = 1'b0;
                        o_flags.escaped             = 1'b0;
                        o_flags.first_of_substring  = 1'b1;
                        o_depth                     = '0;
                    end else begin
                        o_ended      = 1'b1;
                        o_end_offset = pos_inc;
                    end
                end else begin
                    o_depth                    = d_next[DEPTH_W-1:0];
                    o_flags.first_of_substring = 1'b0;
                end
            end
            if (o_ended) begin
                o_flags.finished            = 1'b1;
                o_flags.double_quoted       = 1'b0;
                o_flags.single_quoted       = 1'b0;
                o_flags.escaped             = 1'b0;
                o_flags.first_of_substring  = 1'b1;
                o_flags.pending_space_check = 1'b0;
                o_depth                     = '0;
            end
            o_pos = pos_inc;
        end
    end

endmodule
`default_nettype wire
